@@ hw/rtl/hrl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hrl_pkg
// Shared types, constants and helper functions for the hex record loader.
// ----------------------------------------------------------------------------
package hrl_pkg;

	localparam int STORE_DEPTH = 32768;
	localparam int STAGE_DEPTH = 256;

	localparam int SA_W   = $clog2(STORE_DEPTH);  // store index
	localparam int PA_W   = $clog2(STAGE_DEPTH);  // staging index
	localparam int POS_W  = 10;
	localparam int HW_W   = 17;
	localparam int CNT_W  = PA_W + 1;             // counts 0..STAGE_DEPTH

	localparam logic [POS_W-1:0] POS_MAX   = 10'd1023;
	localparam logic [POS_W-1:0] LINE_MIN  = 10'd11;
	localparam logic [POS_W-1:0] DATA_POS  = 10'd9;
	localparam logic [POS_W-1:0] DATA_END  = 10'(9 + 2 * STAGE_DEPTH);
	localparam logic [7:0]       ERASED    = 8'hFF;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_CHAR  = 2'd1,
		CMD_EOL   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EOF     = 3'd1,
		ST_FORMAT  = 3'd2,
		ST_DAMAGED = 3'd3,
		ST_DROPPED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_COMMIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)
			h.val = 4'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46)
			h.val = 4'(c - 8'h37);
		else if (c >= 8'h61 && c <= 8'h66)
			h.val = 4'(c - 8'h57);
		else
			h.ok = 1'b0;
		return h;
	endfunction

	// characters of the end-of-file line ":00000001FF"
	function automatic logic [7:0] eof_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h3A;
			4'd8:    c = 8'h31;
			4'd9,
			4'd10:   c = 8'h46;
			default: c = 8'h30;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hex_record_loader.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hex_record_loader
// Intel HEX line parser feeding a byte-wide flash image store.
// ----------------------------------------------------------------------------
// A line character is taken while the input stays open. An end-of-line beat
// holds the input while the line is finished: the line is judged, then for an
// accepted record the staged data bytes stream through the registered staging
// read into the image store, one per cycle on the single store write port
// using the one 17-bit address adder, and last the result is posted. A
// rejected line (end of file, bad format, damaged) goes from judgment straight
// to posting, and a store read posts its byte the same way. A stalled output
// register holds end-of-line and read beats until it is free. A clear beat
// sweeps all STORE_DEPTH bytes of the store (32768 by default) to 0xFF one byte
// a cycle; the same sweep runs right after reset, and no beat is taken on the
// input side until it finishes. A result waiting in the output register does
// not block line characters or clears.
// ----------------------------------------------------------------------------
module hex_record_loader (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               command,
	input  wire logic [7:0]               char_code,
	input  wire logic [14:0]              read_address,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [2:0]                    line_status,
	output logic [hrl_pkg::HW_W-1:0]      high_water,
	output logic [7:0]                    read_data
);

	hrl_pkg::state_t state_q, state_nx;

	// line state
	logic [hrl_pkg::POS_W-1:0] pos_q;
	logic [7:0]                count_q;
	logic [15:0]               addr_q;
	logic                      cnt_stop_q, addr_stop_q, pair_stop_q, colon_q;
	logic                      eof_q;
	logic [3:0]                nib_q;
	logic [hrl_pkg::HW_W-1:0]  hw_q;

	// sequencer
	logic [hrl_pkg::SA_W-1:0]  clr_q;
	logic [hrl_pkg::CNT_W-1:0] cnt_q;
	logic                      wr_v_s1;
	logic [hrl_pkg::HW_W-1:0]  wr_addr_s1;
	logic                      drop_q;

	// pending result
	hrl_pkg::status_t          res_status_q;
	logic                      res_read_q, res_oor_q;

	// output register
	logic                      out_valid_q;
	hrl_pkg::status_t          out_status_q;
	logic [hrl_pkg::HW_W-1:0]  out_hw_q;
	logic [7:0]                out_data_q;

	// memories
	logic [7:0] store_mem [hrl_pkg::STORE_DEPTH];
	logic [7:0] stage_mem [hrl_pkg::STAGE_DEPTH];
	logic [7:0] store_rd_q, stage_rd_q;

	// control
	logic                      in_acc, char_acc, clear_acc, eol_acc, read_acc;
	logic                      store_we, store_re, stage_we, stage_re;
	logic [hrl_pkg::SA_W-1:0]  store_wa, store_ra;
	logic [7:0]                store_wd, stage_wd;
	logic [hrl_pkg::PA_W-1:0]  stage_wa;
	logic                      out_load, out_take, line_clear, commit_done;

	// shared address adder
	logic [hrl_pkg::CNT_W-1:0] add_b;
	logic [hrl_pkg::HW_W-1:0]  add_sum;

	// character decode
	hrl_pkg::hex_t             hx;
	logic [hrl_pkg::POS_W-1:0] pos_rel;
	logic                      in_cnt, in_addr, in_data, even_pos, eof_hit;

	// end-of-line judgment
	logic                      is_eof, is_fmt, is_damaged;
	logic [hrl_pkg::POS_W-1:0] need_len;
	logic [hrl_pkg::HW_W-1:0]  rd_addr_ext;

	assign in_acc    = in_valid & ~in_stall;
	assign char_acc  = in_acc & (command == hrl_pkg::CMD_CHAR);
	assign clear_acc = in_acc & (command == hrl_pkg::CMD_CLEAR);
	assign eol_acc   = in_acc & (command == hrl_pkg::CMD_EOL);
	assign read_acc  = in_acc & (command == hrl_pkg::CMD_READ);

	assign out_take = out_valid_q & ~out_stall;

	assign add_b   = (state_q == hrl_pkg::S_COMMIT) ? cnt_q : {1'b0, count_q};
	assign add_sum = hrl_pkg::HW_W'(addr_q) + hrl_pkg::HW_W'(add_b);

	assign hx       = hrl_pkg::hex_decode(char_code);
	assign pos_rel  = pos_q - hrl_pkg::DATA_POS;
	assign in_cnt   = pos_q inside {[10'd1:10'd2]};
	assign in_addr  = pos_q inside {[10'd3:10'd6]};
	assign in_data  = (pos_q >= hrl_pkg::DATA_POS) && (pos_q < hrl_pkg::DATA_END);
	assign even_pos = ~pos_rel[0];
	assign eof_hit  = (pos_q < hrl_pkg::LINE_MIN) && (char_code == hrl_pkg::eof_char(pos_q[3:0]));

	assign need_len   = hrl_pkg::LINE_MIN + {1'b0, count_q, 1'b0};
	assign is_eof     = eof_q && (pos_q == hrl_pkg::LINE_MIN);
	assign is_fmt     = (pos_q == '0) || !colon_q || (pos_q < hrl_pkg::LINE_MIN);
	assign is_damaged = pos_q < need_len;

	assign commit_done = (cnt_q >= {1'b0, count_q}) && !wr_v_s1;
	assign rd_addr_ext = hrl_pkg::HW_W'(read_address);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			hrl_pkg::S_CLEAR: begin
				if (clr_q == hrl_pkg::SA_W'(hrl_pkg::STORE_DEPTH - 1))
					state_nx = hrl_pkg::S_IDLE;
			end
			hrl_pkg::S_IDLE: begin
				if (clear_acc)
					state_nx = hrl_pkg::S_CLEAR;
				else if (eol_acc)
					state_nx = hrl_pkg::S_EVAL;
				else if (read_acc)
					state_nx = hrl_pkg::S_FINISH;
			end
			hrl_pkg::S_EVAL: begin
				if (is_eof || is_fmt || is_damaged)
					state_nx = hrl_pkg::S_FINISH;
				else
					state_nx = hrl_pkg::S_COMMIT;
			end
			hrl_pkg::S_COMMIT: begin
				if (commit_done)
					state_nx = hrl_pkg::S_FINISH;
			end
			hrl_pkg::S_FINISH: begin
				if (!out_valid_q || !out_stall)
					state_nx = hrl_pkg::S_IDLE;
			end
			default: state_nx = hrl_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall   = 1'b1;
		store_we   = 1'b0;
		store_wa   = clr_q;
		store_wd   = hrl_pkg::ERASED;
		store_re   = 1'b0;
		store_ra   = rd_addr_ext[hrl_pkg::SA_W-1:0];
		stage_we   = 1'b0;
		stage_wa   = pos_rel[hrl_pkg::PA_W:1];
		stage_wd   = even_pos ? {4'd0, hx.ok ? hx.val : 4'd0} : {nib_q, hx.val};
		stage_re   = 1'b0;
		out_load   = 1'b0;
		line_clear = 1'b0;
		case (state_q)
			hrl_pkg::S_CLEAR: begin
				store_we = 1'b1;
			end
			hrl_pkg::S_IDLE: begin
				in_stall = 1'b0;
				store_re = read_acc;
				stage_we = char_acc && in_data && (even_pos || (!pair_stop_q && hx.ok));
			end
			hrl_pkg::S_EVAL: begin
				line_clear = is_eof || is_fmt || is_damaged;
			end
			hrl_pkg::S_COMMIT: begin
				stage_re   = cnt_q < {1'b0, count_q};
				store_we   = wr_v_s1 && (wr_addr_s1 < hrl_pkg::HW_W'(hrl_pkg::STORE_DEPTH));
				store_wa   = wr_addr_s1[hrl_pkg::SA_W-1:0];
				store_wd   = stage_rd_q;
				line_clear = commit_done;
			end
			hrl_pkg::S_FINISH: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	// control and line registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hrl_pkg::S_CLEAR;
			clr_q        <= '0;
			pos_q        <= '0;
			count_q      <= '0;
			addr_q       <= '0;
			cnt_stop_q   <= 1'b0;
			addr_stop_q  <= 1'b0;
			pair_stop_q  <= 1'b0;
			colon_q      <= 1'b0;
			eof_q        <= 1'b1;
			nib_q        <= '0;
			hw_q         <= '0;
			cnt_q        <= '0;
			wr_v_s1      <= 1'b0;
			wr_addr_s1   <= '0;
			drop_q       <= 1'b0;
			res_status_q <= hrl_pkg::ST_OK;
			res_read_q   <= 1'b0;
			res_oor_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= hrl_pkg::ST_OK;
			out_hw_q     <= '0;
			out_data_q   <= '0;
		end else begin
			state_q <= state_nx;

			if (state_q == hrl_pkg::S_CLEAR)
				clr_q <= clr_q + 1'b1;
			else
				clr_q <= '0;

			if (clear_acc)
				hw_q <= '0;

			if (char_acc) begin
				if (!eof_hit)
					eof_q <= 1'b0;
				if (pos_q == '0) begin
					if (char_code == 8'h3A)
						colon_q <= 1'b1;
				end else if (in_cnt) begin
					if (!cnt_stop_q) begin
						if (!hx.ok)
							cnt_stop_q <= 1'b1;
						else
							count_q <= {count_q[3:0], hx.val};
					end
				end else if (in_addr) begin
					if (!addr_stop_q) begin
						if (!hx.ok)
							addr_stop_q <= 1'b1;
						else
							addr_q <= {addr_q[11:0], hx.val};
					end
				end else if (in_data && even_pos) begin
					pair_stop_q <= !hx.ok;
					nib_q       <= hx.ok ? hx.val : 4'd0;
				end
				if (pos_q != hrl_pkg::POS_MAX)
					pos_q <= pos_q + 1'b1;
			end

			if (read_acc) begin
				res_status_q <= hrl_pkg::ST_OK;
				res_read_q   <= 1'b1;
				res_oor_q    <= rd_addr_ext >= hrl_pkg::HW_W'(hrl_pkg::STORE_DEPTH);
			end

			if (state_q == hrl_pkg::S_EVAL) begin
				res_read_q <= 1'b0;
				cnt_q      <= '0;
				wr_v_s1    <= 1'b0;
				drop_q     <= 1'b0;
				if (is_eof)
					res_status_q <= hrl_pkg::ST_EOF;
				else if (is_fmt)
					res_status_q <= hrl_pkg::ST_FORMAT;
				else begin
					if (hw_q < add_sum)
						hw_q <= add_sum;
					if (is_damaged)
						res_status_q <= hrl_pkg::ST_DAMAGED;
				end
			end

			if (state_q == hrl_pkg::S_COMMIT) begin
				// s1: staged byte is being read, store address is known
				wr_v_s1    <= stage_re;
				wr_addr_s1 <= add_sum;
				if (stage_re)
					cnt_q <= cnt_q + 1'b1;
				if (wr_v_s1 && !store_we)
					drop_q <= 1'b1;
				if (commit_done)
					res_status_q <= drop_q ? hrl_pkg::ST_DROPPED : hrl_pkg::ST_OK;
			end

			if (line_clear) begin
				pos_q       <= '0;
				count_q     <= '0;
				addr_q      <= '0;
				cnt_stop_q  <= 1'b0;
				addr_stop_q <= 1'b0;
				pair_stop_q <= 1'b0;
				colon_q     <= 1'b0;
				eof_q       <= 1'b1;
			end

			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_hw_q     <= hw_q;
				if (!res_read_q)
					out_data_q <= 8'd0;
				else if (res_oor_q)
					out_data_q <= hrl_pkg::ERASED;
				else
					out_data_q <= store_rd_q;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// image store
	always_ff @(posedge clk) begin
		if (store_we)
			store_mem[store_wa] <= store_wd;
		if (store_re)
			store_rd_q <= store_mem[store_ra];
	end

	// record staging
	always_ff @(posedge clk) begin
		if (stage_we)
			stage_mem[stage_wa] <= stage_wd;
		if (stage_re)
			stage_rd_q <= stage_mem[cnt_q[hrl_pkg::PA_W-1:0]];
	end

	assign out_valid   = out_valid_q;
	assign line_status = out_status_q;
	assign high_water  = out_hw_q;
	assign read_data   = out_data_q;

endmodule
`default_nettype wire

@@ hw/rtl/hrl_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hrl_checker
// Port-level checks for the hex record loader, bound to the top level.
// ----------------------------------------------------------------------------
module hrl_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_stall,
	input wire logic [1:0]               command,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input wire logic [2:0]               line_status,
	input wire logic [hrl_pkg::HW_W-1:0] high_water,
	input wire logic [7:0]               read_data
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(line_status)
			&& $stable(high_water) && $stable(read_data))
		else $error("result beat changed while stalled");

	// a clear starts the erase sweep, input side closes
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && command == hrl_pkg::CMD_CLEAR |=> in_stall)
		else $error("input open right after clear");

	// a beat that yields a result closes the input once it is taken
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (command == hrl_pkg::CMD_EOL || command == hrl_pkg::CMD_READ)
			|=> in_stall)
		else $error("input open while a result is pending");

	// only end-of-line results carry a non-ok status, and those return no data
	a_status_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_status != hrl_pkg::ST_OK |-> read_data == 8'd0)
		else $error("data returned with a line status");

	// a character beat that is taken never produces a result on its own
	a_char_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && command == hrl_pkg::CMD_CHAR && !out_valid |=> !out_valid)
		else $error("result after a line character");

endmodule

bind hex_record_loader hrl_checker u_hrl_checker (.*);
`default_nettype wire
